// File: sv/cra_pkg.sv
`default_nettype none
package cra_pkg;

	localparam int OFF_W = 10;
	localparam int CNT_W = 11;
	localparam int TAG_W = 32;
	localparam int REL_W = 7;
	localparam int ADDR_W = 1;
	localparam int DATA_W = 32;

	localparam logic [CNT_W-1:0] MAX_SLOTS = 11'd1024;
	localparam logic [CNT_W-1:0] HEAP_SIZE_RST = 11'd1024;

	localparam logic [ADDR_W-1:0] REG_HEAP_SIZE = 1'b0;

	typedef enum logic [1:0] {
		FUNC_ALLOC   = 2'd0,
		FUNC_RETIRE  = 2'd1,
		FUNC_RELEASE = 2'd2,
		FUNC_QUERY   = 2'd3
	} func_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic             vld;
		logic [OFF_W-1:0] start;
		logic [CNT_W-1:0] len;
	} run_entry_t;

	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [CNT_W-1:0] cnt;
		logic [TAG_W-1:0] tag;
	} stale_entry_t;

	typedef struct packed {
		logic clr;
		logic push;
		logic pop;
		logic rd;
	} fifo_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_sts_t;

endpackage
`default_nettype wire

// File: sv/coalescing_range_allocator.sv
// allocate scans the run table and, when a run fits, writes the remainder back; retire and fit query
// take a single scan; release checks each queued run, scans for each good one and merges it,
// then ends with a closing fits scan; the run-table scan reads one entry per cycle
// throughput: one request at a time; busy stays high until the result strobe
// reset and every heap_size write start a clearing pass over all MAX_RUNS table entries with busy high
// the receiver cannot stall: done marks each result for exactly one cycle
`default_nettype none
module coalescing_range_allocator
	import cra_pkg::*;
#(
	parameter int MAX_RUNS = 512,
	parameter int STALE_DEPTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request channel
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        func,
	input  wire logic [CNT_W-1:0]  request_count,
	input  wire logic [OFF_W-1:0]  block_offset,
	input  wire logic [TAG_W-1:0]  frame_tag,
	// result channel
	output logic                   done,
	output logic [1:0]             status,
	output logic [OFF_W-1:0]       grant_offset,
	output logic [REL_W-1:0]       released_runs,
	output logic [CNT_W-1:0]       free_total,
	output logic                   fits,
	// configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	localparam int IW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
	localparam int CW = $clog2(MAX_RUNS + 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_ALLOC_WR,
		S_RL_RD,
		S_RL_CHK,
		S_MWR1,
		S_MWR2
	} state_t;

	state_t state_q;

	// configuration
	logic [CNT_W-1:0] hs_q;
	logic [CNT_W-1:0] size_in_use;
	logic [CNT_W-1:0] wr_size;
	logic             cfg_we;

	// latched request
	func_t            func_q;
	logic [CNT_W-1:0] req_q;
	logic [TAG_W-1:0] tag_q;
	logic [CNT_W-1:0] free_q;
	logic             merge_q;

	// run being merged
	logic [OFF_W-1:0] mo_q;
	logic [CNT_W-1:0] mc_q;

	// run table memory, one synchronous read port and one write port
	run_entry_t tbl_mem [MAX_RUNS];
	run_entry_t tbl_rd_q;
	logic       tbl_we;
	logic [IW-1:0] tbl_wa;
	run_entry_t tbl_wd;
	logic       tbl_re;

	logic [IW-1:0] clr_q;
	logic [CW-1:0] issue_q;
	logic          sv_s1;
	logic [IW-1:0] idx_s1;
	logic          scan_init;
	logic          scan_done;

	// scan accumulators
	logic             bhave_q;
	logic [IW-1:0]    bidx_q;
	logic [OFF_W-1:0] bstart_q;
	logic [CNT_W-1:0] blen_q;
	logic [1:0]       fcnt_q;
	logic             ov_q;
	logic             phave_q;
	logic [IW-1:0]    pidx_q;
	logic [OFF_W-1:0] pstart_q;
	logic [CNT_W-1:0] plen_q;
	logic             nhave_q;
	logic [IW-1:0]    nidx_q;
	logic [CNT_W-1:0] nlen_q;
	logic             ehave_q;
	logic [IW-1:0]    eidx_q;

	// per-entry evaluation
	logic [CNT_W:0] e_end;
	logic [CNT_W:0] m_end;
	logic           e_fit;
	logic           e_better;
	logic           e_ovl;
	logic           e_prev;
	logic           e_next;
	logic           e_emp;

	// allocate remainder
	logic [CNT_W-1:0] new_len;
	logic [OFF_W-1:0] new_start;

	// retire queue
	fifo_ctl_t    fctl;
	fifo_sts_t    fsts;
	stale_entry_t fwr;
	stale_entry_t frd;
	logic         rd_take;
	logic         rd_bad;

	// result registers
	logic             done_q;
	logic [1:0]       st_q;
	logic [OFF_W-1:0] grant_q;
	logic [REL_W-1:0] rel_q;
	logic             fits_q;

	// heap size saturates at the slot capacity
	assign size_in_use = (hs_q > MAX_SLOTS) ? MAX_SLOTS : hs_q;
	assign wr_size     = (pwdata[CNT_W-1:0] > MAX_SLOTS) ? MAX_SLOTS : pwdata[CNT_W-1:0];

	assign cfg_we = psel && penable && pwrite && (paddr == REG_HEAP_SIZE);
	assign pready = 1'b1;
	assign prdata = (paddr == REG_HEAP_SIZE) ? DATA_W'(hs_q) : '0;

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = st_q;
	assign grant_offset  = grant_q;
	assign released_runs = rel_q;
	assign free_total    = free_q;
	assign fits          = fits_q;

	// retire queue hookup
	assign fwr.off = block_offset;
	assign fwr.cnt = request_count;
	assign fwr.tag = frame_tag;

	assign fctl.clr  = cfg_we;
	assign fctl.push = !cfg_we && (state_q == S_IDLE) && start
		&& (func_t'(func) == FUNC_RETIRE) && !fsts.full;
	assign fctl.rd   = !cfg_we && (state_q == S_RL_RD) && !fsts.empty;
	assign fctl.pop  = !cfg_we && (state_q == S_RL_CHK) && rd_take;

	assign rd_take = (frd.tag <= tag_q);
	assign rd_bad  = (frd.cnt == '0)
		|| (({2'b00, frd.off} + {1'b0, frd.cnt}) > {1'b0, size_in_use});

	cra_stale_fifo #(
		.DEPTH(STALE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (fctl),
		.wr_entry (fwr),
		.rd_entry (frd),
		.sts      (fsts)
	);

	// table scan: one read issued per cycle, data evaluated in the following cycle
	assign tbl_re    = (state_q == S_SCAN) && (issue_q != CW'(MAX_RUNS));
	assign scan_done = (state_q == S_SCAN) && (issue_q == CW'(MAX_RUNS)) && !sv_s1;

	assign e_end    = {2'b00, tbl_rd_q.start} + {1'b0, tbl_rd_q.len};
	assign m_end    = {2'b00, mo_q} + {1'b0, mc_q};
	assign e_fit    = tbl_rd_q.vld && (req_q != '0) && (tbl_rd_q.len >= req_q);
	assign e_better = !bhave_q || (tbl_rd_q.len < blen_q)
		|| ((tbl_rd_q.len == blen_q) && (tbl_rd_q.start < bstart_q));
	assign e_ovl    = tbl_rd_q.vld && ({2'b00, tbl_rd_q.start} < m_end)
		&& ({2'b00, mo_q} < e_end);
	assign e_prev   = tbl_rd_q.vld && (e_end == {2'b00, mo_q});
	assign e_next   = tbl_rd_q.vld && ({2'b00, tbl_rd_q.start} == m_end);
	assign e_emp    = !tbl_rd_q.vld && !ehave_q;

	assign new_len   = blen_q - req_q;
	assign new_start = bstart_q + req_q[OFF_W-1:0];

	// scan start points: accepted request, popped good run, closing fits scan
	always_comb begin
		scan_init = 1'b0;
		if (!cfg_we) begin
			unique case (state_q)
				S_IDLE: begin
					scan_init = start && (func_t'(func) != FUNC_RELEASE);
				end
				S_RL_RD: begin
					scan_init = fsts.empty;
				end
				S_RL_CHK: begin
					scan_init = !rd_take || !rd_bad;
				end
				default: begin
					scan_init = 1'b0;
				end
			endcase
		end
	end

	// table write port
	always_comb begin
		tbl_we = 1'b0;
		tbl_wa = '0;
		tbl_wd = '0;
		unique case (state_q)
			S_CLEAR: begin
				tbl_we = 1'b1;
				tbl_wa = clr_q;
				if (clr_q == '0) begin
					tbl_wd.vld = (size_in_use != '0);
					tbl_wd.len = size_in_use;
				end
			end
			S_ALLOC_WR: begin
				tbl_we       = 1'b1;
				tbl_wa       = bidx_q;
				tbl_wd.vld   = (new_len != '0);
				tbl_wd.start = new_start;
				tbl_wd.len   = new_len;
			end
			S_MWR1: begin
				tbl_we = 1'b1;
				tbl_wd.vld = 1'b1;
				if (phave_q) begin
					// extend the run below, and swallow the run above if any
					tbl_wa       = pidx_q;
					tbl_wd.start = pstart_q;
					tbl_wd.len   = plen_q + mc_q + (nhave_q ? nlen_q : '0);
				end else if (nhave_q) begin
					tbl_wa       = nidx_q;
					tbl_wd.start = mo_q;
					tbl_wd.len   = nlen_q + mc_q;
				end else begin
					tbl_wa       = eidx_q;
					tbl_wd.start = mo_q;
					tbl_wd.len   = mc_q;
				end
			end
			S_MWR2: begin
				tbl_we = 1'b1;
				tbl_wa = nidx_q;
			end
			default: begin
				tbl_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_wa] <= tbl_wd;
		end
		if (tbl_re) begin
			tbl_rd_q <= tbl_mem[issue_q[IW-1:0]];
		end
	end

	// scan accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= '0;
			sv_s1   <= 1'b0;
			idx_s1  <= '0;
			bhave_q <= 1'b0;
			fcnt_q  <= '0;
			ov_q    <= 1'b0;
			phave_q <= 1'b0;
			nhave_q <= 1'b0;
			ehave_q <= 1'b0;
		end else if (scan_init) begin
			issue_q <= '0;
			sv_s1   <= 1'b0;
			bhave_q <= 1'b0;
			fcnt_q  <= '0;
			ov_q    <= 1'b0;
			phave_q <= 1'b0;
			nhave_q <= 1'b0;
			ehave_q <= 1'b0;
		end else begin
			sv_s1  <= tbl_re;
			idx_s1 <= issue_q[IW-1:0];
			if (tbl_re) begin
				issue_q <= issue_q + 1'b1;
			end
			if (sv_s1) begin
				if (e_fit) begin
					if (fcnt_q != 2'd2) begin
						fcnt_q <= fcnt_q + 1'b1;
					end
					if (e_better) begin
						bhave_q <= 1'b1;
					end
				end
				if (e_ovl) begin
					ov_q <= 1'b1;
				end
				if (e_prev) begin
					phave_q <= 1'b1;
				end
				if (e_next) begin
					nhave_q <= 1'b1;
				end
				if (e_emp) begin
					ehave_q <= 1'b1;
				end
			end
		end
	end

	// scan payload, no reset needed
	always_ff @(posedge clk) begin
		if (sv_s1 && !scan_init) begin
			if (e_fit && e_better) begin
				bidx_q   <= idx_s1;
				bstart_q <= tbl_rd_q.start;
				blen_q   <= tbl_rd_q.len;
			end
			if (e_prev) begin
				pidx_q   <= idx_s1;
				pstart_q <= tbl_rd_q.start;
				plen_q   <= tbl_rd_q.len;
			end
			if (e_next) begin
				nidx_q <= idx_s1;
				nlen_q <= tbl_rd_q.len;
			end
			if (e_emp) begin
				eidx_q <= idx_s1;
			end
		end
	end

	// sequencer with registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			hs_q    <= HEAP_SIZE_RST;
			free_q  <= HEAP_SIZE_RST;
			clr_q   <= '0;
			func_q  <= FUNC_ALLOC;
			merge_q <= 1'b0;
			done_q  <= 1'b0;
			st_q    <= ST_OK;
			grant_q <= '0;
			rel_q   <= '0;
			fits_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				// new heap size: whole range becomes one free run
				hs_q    <= pwdata[CNT_W-1:0];
				free_q  <= wr_size;
				clr_q   <= '0;
				state_q <= S_CLEAR;
			end else begin
				unique case (state_q)
					S_CLEAR: begin
						clr_q <= clr_q + 1'b1;
						if (clr_q == IW'(MAX_RUNS - 1)) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (start) begin
							func_q  <= func_t'(func);
							req_q   <= request_count;
							tag_q   <= frame_tag;
							merge_q <= 1'b0;
							rel_q   <= '0;
							grant_q <= '0;
							st_q    <= ST_OK;
							if ((func_t'(func) == FUNC_RETIRE) && fsts.full) begin
								st_q <= ST_FULL;
							end
							if (func_t'(func) == FUNC_RELEASE) begin
								state_q <= S_RL_RD;
							end else begin
								state_q <= S_SCAN;
							end
						end
					end
					S_SCAN: begin
						if (scan_done) begin
							if (merge_q) begin
								if (!ov_q && (phave_q || nhave_q || ehave_q)) begin
									state_q <= S_MWR1;
								end else begin
									// overlapping run or full table: dropped
									state_q <= S_RL_RD;
								end
							end else if ((func_q == FUNC_ALLOC) && (req_q <= free_q)
									&& bhave_q) begin
								state_q <= S_ALLOC_WR;
							end else begin
								if (func_q == FUNC_ALLOC) begin
									st_q <= ST_NOFIT;
								end
								fits_q  <= (fcnt_q != '0);
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						end
					end
					S_ALLOC_WR: begin
						// fits after the grant: another run, or the remainder
						grant_q <= bstart_q;
						free_q  <= free_q - req_q;
						fits_q  <= (fcnt_q == 2'd2) || (new_len >= req_q);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
					S_RL_RD: begin
						if (fsts.empty) begin
							merge_q <= 1'b0;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_RL_CHK;
						end
					end
					S_RL_CHK: begin
						if (rd_take) begin
							rel_q <= rel_q + 1'b1;
							mo_q  <= frd.off;
							mc_q  <= frd.cnt;
							if (rd_bad) begin
								state_q <= S_RL_RD;
							end else begin
								merge_q <= 1'b1;
								state_q <= S_SCAN;
							end
						end else begin
							merge_q <= 1'b0;
							state_q <= S_SCAN;
						end
					end
					S_MWR1: begin
						free_q <= free_q + mc_q;
						if (phave_q && nhave_q) begin
							state_q <= S_MWR2;
						end else begin
							state_q <= S_RL_RD;
						end
					end
					S_MWR2: begin
						state_q <= S_RL_RD;
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/cra_stale_fifo.sv
`default_nettype none
module cra_stale_fifo
	import cra_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire fifo_ctl_t    ctl,
	input  wire stale_entry_t wr_entry,
	output stale_entry_t      rd_entry,
	output fifo_sts_t         sts
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);
	localparam int SW = FW + 1;

	stale_entry_t mem [DEPTH];
	logic [PW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [SW-1:0] tail_sum;
	logic [SW-1:0] tail_wrap;
	logic [PW-1:0] head_nxt;

	// tail index wraps at a depth that need not be a power of two
	assign tail_sum  = SW'(head_q) + SW'(fill_q);
	assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
	assign head_nxt  = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + 1'b1;

	assign sts.empty = (fill_q == '0);
	assign sts.full  = (fill_q == FW'(DEPTH));

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail_wrap[PW-1:0]] <= wr_entry;
		end
		if (ctl.rd) begin
			rd_entry <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (ctl.clr) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (ctl.push) begin
			fill_q <= fill_q + 1'b1;
		end else if (ctl.pop) begin
			head_q <= head_nxt;
			fill_q <= fill_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// File: sv/cra_checker.sv
`default_nettype none
module cra_checker
	import cra_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire logic [1:0]        status,
	input wire logic [CNT_W-1:0]  free_total,
	input wire logic [REL_W-1:0]  released_runs
);

	// an accepted request keeps the block busy next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low after accepted request");

	// one result per request, never in consecutive cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_NOFIT || status == ST_FULL))
		else $error("bad status code");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (free_total <= MAX_SLOTS))
		else $error("free total above capacity");

	a_release_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && released_runs != '0) |-> (status == ST_OK))
		else $error("released runs with error status");

endmodule

bind coalescing_range_allocator cra_checker u_cra_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.free_total    (free_total),
	.released_runs (released_runs)
);
`default_nettype wire

// File: dv/coalescing_range_allocator_tb.sv
`default_nettype none
module coalescing_range_allocator_tb;
	import cra_pkg::*;

	localparam int RUNS  = 512;
	localparam int DEPTH = 64;

	// one expected result per request
	typedef struct packed {
		logic [1:0]       status;
		logic [OFF_W-1:0] grant;
		logic [REL_W-1:0] released;
		logic [CNT_W-1:0] free;
		logic             fits;
	} alloc_result_t;

	// a run handed out by the block and not yet retired
	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [CNT_W-1:0] cnt;
	} granted_run_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        func = FUNC_QUERY;
	logic [CNT_W-1:0]  request_count = '0;
	logic [OFF_W-1:0]  block_offset = '0;
	logic [TAG_W-1:0]  frame_tag = '0;
	logic              done;
	logic [1:0]        status;
	logic [OFF_W-1:0]  grant_offset;
	logic [REL_W-1:0]  released_runs;
	logic [CNT_W-1:0]  free_total;
	logic              fits;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	coalescing_range_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .func(func), .request_count(request_count),
		.block_offset(block_offset), .frame_tag(frame_tag),
		.done(done), .status(status), .grant_offset(grant_offset),
		.released_runs(released_runs), .free_total(free_total), .fits(fits),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	// mirror of the allocator state
	logic [CNT_W-1:0] heap_reg;
	logic [OFF_W-1:0] run_off [RUNS];
	logic [CNT_W-1:0] run_len [RUNS];
	logic             run_live [RUNS];
	logic [CNT_W-1:0] slots_free;
	logic [OFF_W-1:0] stale_off [DEPTH];
	logic [CNT_W-1:0] stale_cnt [DEPTH];
	logic [TAG_W-1:0] stale_tag [DEPTH];
	int               stale_fill;
	int               stale_head;

	alloc_result_t    pending_results [$];
	granted_run_t     granted_runs [$];
	int               mismatches = 0;
	logic             no_idle = 1'b0;
	logic [TAG_W-1:0] frame_no = '0;

	function automatic int heap_in_use();
		return (heap_reg > MAX_SLOTS) ? int'(MAX_SLOTS) : int'(heap_reg);
	endfunction

	// clear the table and the retire queue, whole heap becomes one free run
	task automatic heap_reinit();
		int sz;
		sz = heap_in_use();
		for (int i = 0; i < RUNS; i++) begin
			run_live[i] = 1'b0;
			run_off[i] = '0;
			run_len[i] = '0;
		end
		stale_fill = 0;
		stale_head = 0;
		slots_free = '0;
		if (sz > 0) begin
			run_live[0] = 1'b1;
			run_len[0] = CNT_W'(sz);
			slots_free = CNT_W'(sz);
		end
	endtask

	// smallest run that holds n, lowest start on a tie
	function automatic int smallest_fit(int n);
		int best;
		best = -1;
		if (n == 0)
			return -1;
		for (int i = 0; i < RUNS; i++) begin
			if (!run_live[i] || run_len[i] < n)
				continue;
			if (best < 0 || run_len[i] < run_len[best] ||
			    (run_len[i] == run_len[best] && run_off[i] < run_off[best]))
				best = i;
		end
		return best;
	endfunction

	// give a retired run back, joining free neighbours on either side
	task automatic coalesce_run(int off, int cnt);
		int lower, upper, hole, stop;
		lower = -1;
		upper = -1;
		hole = -1;
		stop = off + cnt;
		if (cnt == 0 || stop > heap_in_use())
			return;
		for (int i = 0; i < RUNS; i++) begin
			if (!run_live[i]) begin
				if (hole < 0)
					hole = i;
				continue;
			end
			// overlap with a free run: the retired run is dropped
			if (run_off[i] < stop && off < run_off[i] + run_len[i])
				return;
			if (run_off[i] + run_len[i] == off)
				lower = i;
			if (run_off[i] == stop)
				upper = i;
		end
		if (lower >= 0) begin
			run_len[lower] += cnt;
			if (upper >= 0) begin
				run_len[lower] += run_len[upper];
				run_live[upper] = 1'b0;
			end
		end else if (upper >= 0) begin
			run_off[upper] = OFF_W'(off);
			run_len[upper] += cnt;
		end else if (hole >= 0) begin
			run_off[hole] = OFF_W'(off);
			run_len[hole] = CNT_W'(cnt);
			run_live[hole] = 1'b1;
		end else begin
			return;
		end
		slots_free += cnt;
	endtask

	// work out the result of one accepted request and advance the mirror
	task automatic predict_request(input logic [1:0] f, input logic [CNT_W-1:0] req,
			input logic [OFF_W-1:0] boff, input logic [TAG_W-1:0] tag,
			output alloc_result_t r);
		int pick, popped, slot;
		r = '0;
		popped = 0;
		case (f)
			FUNC_ALLOC: begin
				pick = (req <= slots_free) ? smallest_fit(req) : -1;
				if (pick < 0) begin
					r.status = ST_NOFIT;
				end else begin
					r.grant = run_off[pick];
					run_off[pick] += req[OFF_W-1:0];
					run_len[pick] -= req;
					if (run_len[pick] == 0)
						run_live[pick] = 1'b0;
					slots_free -= req;
				end
			end
			FUNC_RETIRE: begin
				if (stale_fill >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					slot = (stale_head + stale_fill) % DEPTH;
					stale_off[slot] = boff;
					stale_cnt[slot] = req;
					stale_tag[slot] = tag;
					stale_fill++;
				end
			end
			FUNC_RELEASE: begin
				while (stale_fill > 0 && stale_tag[stale_head] <= tag) begin
					coalesce_run(stale_off[stale_head], stale_cnt[stale_head]);
					stale_head = (stale_head + 1) % DEPTH;
					stale_fill--;
					popped++;
				end
			end
			default: ;
		endcase
		r.released = REL_W'(popped);
		r.free = slots_free;
		r.fits = (smallest_fit(req) >= 0);
	endtask

	// hand one request over; start stays up until the next request or an idle
	task automatic send_request(input logic [1:0] f, input logic [CNT_W-1:0] req,
			input logic [OFF_W-1:0] boff, input logic [TAG_W-1:0] tag,
			output alloc_result_t r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 14);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		func <= f;
		request_count <= req;
		block_offset <= boff;
		frame_tag <= tag;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		predict_request(f, req, boff, tag, r);
		pending_results.push_back(r);
	endtask

	task automatic go_quiet();
		@(negedge clk);
		start <= 1'b0;
	endtask

	// write heap_size once the block has nothing in flight, then read it back
	task automatic write_heap_size(input logic [DATA_W-1:0] value);
		go_quiet();
		wait (pending_results.size() == 0);
		@(negedge clk);
		while (busy) @(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= REG_HEAP_SIZE;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CNT_W-1:0] !== value[CNT_W-1:0]) begin
			$error("heap_size readback: expected %0d, got %0d", value[CNT_W-1:0],
			       prdata[CNT_W-1:0]);
			mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		heap_reg = value[CNT_W-1:0];
		heap_reinit();
		granted_runs.delete();
	endtask

	// compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		alloc_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result strobe with no request outstanding");
				mismatches++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status);
					mismatches++;
				end
				if (grant_offset !== e.grant) begin
					$error("grant_offset: expected %0d, got %0d", e.grant, grant_offset);
					mismatches++;
				end
				if (released_runs !== e.released) begin
					$error("released_runs: expected %0d, got %0d", e.released,
					       released_runs);
					mismatches++;
				end
				if (free_total !== e.free) begin
					$error("free_total: expected %0d, got %0d", e.free, free_total);
					mismatches++;
				end
				if (fits !== e.fits) begin
					$error("fits: expected %0d, got %0d", e.fits, fits);
					mismatches++;
				end
			end
		end
	end

	// corners: empty and full requests, every func, bad retired runs, queue overflow
	task automatic test_directed();
		alloc_result_t r;
		send_request(FUNC_QUERY, 11'd1024, '0, '0, r);
		send_request(FUNC_QUERY, 11'd0, '0, '0, r);
		send_request(FUNC_ALLOC, 11'd0, '0, '0, r);
		send_request(FUNC_ALLOC, 11'd2047, '0, '0, r);
		send_request(FUNC_ALLOC, 11'd3, '0, '0, r);
		send_request(FUNC_ALLOC, 11'd1, '0, '0, r);
		send_request(FUNC_ALLOC, 11'd1020, '0, '0, r);
		send_request(FUNC_ALLOC, 11'd1, '0, '0, r);
		// freed middle run, then a run that joins it from below
		send_request(FUNC_RETIRE, 11'd1, 10'd3, 32'd5, r);
		send_request(FUNC_RETIRE, 11'd0, 10'd9, 32'd5, r);
		send_request(FUNC_RETIRE, 11'd2, 10'd1023, 32'd6, r);
		send_request(FUNC_RETIRE, 11'd1, 10'd3, 32'd6, r);
		send_request(FUNC_RETIRE, 11'd3, 10'd0, 32'hFFFF_FFFF, r);
		send_request(FUNC_RELEASE, 11'd4, '0, 32'd4, r);
		send_request(FUNC_RELEASE, 11'd4, '0, 32'd6, r);
		send_request(FUNC_RELEASE, 11'd4, 10'd1023, 32'hFFFF_FFFF, r);
		// overflow the retire queue, then drain it in one release
		for (int i = 0; i <= DEPTH; i++)
			send_request(FUNC_RETIRE, 11'd1, 10'd1023, 32'd7, r);
		send_request(FUNC_RETIRE, 11'd2047, 10'd1023, 32'hFFFF_FFFF, r);
		send_request(FUNC_RELEASE, 11'd1, '0, 32'hFFFF_FFFF, r);
		send_request(FUNC_QUERY, 11'd1024, '0, '0, r);
	endtask

	// allocate, retire and release in well-formed order with some noise mixed in
	task automatic test_random_traffic(int n_items, int max_req);
		alloc_result_t r;
		granted_run_t g;
		int pick, sel;
		for (int k = 0; k < n_items; k++) begin
			if (k % 64 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				send_request(FUNC_ALLOC, CNT_W'($urandom_range(1, max_req >> $urandom_range(0, 4))),
				             OFF_W'($urandom), $urandom, r);
				if (r.status == ST_OK) begin
					g.off = r.grant;
					g.cnt = request_count;
					granted_runs.push_back(g);
				end
			end else if (sel < 70 && granted_runs.size() > 0) begin
				pick = $urandom_range(0, granted_runs.size() - 1);
				g = granted_runs[pick];
				granted_runs.delete(pick);
				frame_no += $urandom_range(0, 2);
				send_request(FUNC_RETIRE, g.cnt, g.off, frame_no, r);
			end else if (sel < 85) begin
				send_request(FUNC_RELEASE, CNT_W'($urandom_range(1, max_req)), OFF_W'($urandom),
				             frame_no - $urandom_range(0, 4), r);
			end else if (sel < 95) begin
				send_request(FUNC_QUERY, CNT_W'($urandom_range(0, max_req)), OFF_W'($urandom),
				             $urandom, r);
			end else begin
				send_request(2'($urandom), CNT_W'($urandom), OFF_W'($urandom), $urandom, r);
			end
		end
		no_idle = 1'b0;
	endtask

	// heap sizes: extremes, saturation and zero
	task automatic test_heap_sizes();
		alloc_result_t r;
		write_heap_size(32'd0);
		send_request(FUNC_ALLOC, 11'd1, '0, '0, r);
		send_request(FUNC_RETIRE, 11'd1, '0, '0, r);
		send_request(FUNC_RELEASE, 11'd1, '0, '0, r);
		write_heap_size(32'd2047);
		send_request(FUNC_QUERY, 11'd1024, '0, '0, r);
		send_request(FUNC_QUERY, 11'd1025, '0, '0, r);
		write_heap_size(32'd1);
		test_random_traffic(60, 2);
		write_heap_size(32'd16);
		test_random_traffic(150, 16);
		write_heap_size(32'($urandom_range(2, 1023)));
		test_random_traffic(200, 64);
		write_heap_size(32'd1024);
	endtask

	initial begin
		heap_reg = HEAP_SIZE_RST;
		heap_reinit();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_traffic(600, 1024);
		test_heap_sizes();
		test_random_traffic(50, 1024);
		go_quiet();
		wait (pending_results.size() == 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("coalescing_range_allocator verification clean");
		else
			$display("coalescing_range_allocator verification failed");
		$finish;
	end

	// release may walk the whole queue, each merge a full table scan
	initial begin
		#80_000_000;
		$display("coalescing_range_allocator verification failed");
		$finish;
	end

endmodule
`default_nettype wire
